// File: rtl/osd_ab_pkg.sv
// Shared types, codes and per-lane blend function for the OSD alpha blender.
package osd_ab_pkg;

   // Pixel format codes held in the pixel_format register
   typedef enum logic [2:0] {
      FMT_Y_PLANE = 3'd0,
      FMT_YUY2    = 3'd1,
      FMT_RGB24   = 3'd2,
      FMT_RGB32   = 3'd3,
      FMT_RGB15   = 3'd4,
      FMT_RGB16   = 3'd5
   } fmt_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_PIXEL_FORMAT = 1'b0,
      CSR_COPY_MODE    = 1'b1
   } csr_index_type;

   // How one lane is interpreted
   typedef enum logic [1:0] {
      LANE_BYTE   = 2'd0,
      LANE_FIELD5 = 2'd1,
      LANE_FIELD6 = 2'd2
   } lane_kind_type;

   localparam int unsigned NUM_LANES = 3;
   localparam logic [5:0]  FIELD5_MAX = 6'h1F;
   localparam logic [6:0]  FIELD6_MAX = 7'h3F;

   // Lane kind for a lane index under a format
   function automatic lane_kind_type lane_kind(input logic [2:0] fmt,
                                               input logic [1:0] lane);
      lane_kind_type kind;
      kind = LANE_BYTE;
      if (fmt == FMT_RGB15) begin
         kind = LANE_FIELD5;
      end else if (fmt == FMT_RGB16) begin
         kind = (lane == 2'd1) ? LANE_FIELD6 : LANE_FIELD5;
      end
      return kind;
   endfunction

   // Scale a registered lane product, add overlay, saturate fields; or copy
   function automatic logic [7:0] lane_blend(input logic [15:0]    prod,
                                             input logic [7:0]     ovl,
                                             input logic           copy,
                                             input lane_kind_type  kind);
      logic [8:0] sum;
      logic [5:0] v5;
      logic [6:0] v6;
      logic [7:0] res;
      sum = 9'd0;
      v5  = 6'd0;
      v6  = 7'd0;
      res = 8'd0;
      case (kind)
         LANE_FIELD5: begin
            sum = {1'b0, prod[12:5]} + {1'b0, ovl};
            v5  = sum[8:3];
            if (copy) begin
               res = {3'b000, ovl[7:3]};
            end else if (v5 > FIELD5_MAX) begin
               res = {2'b00, FIELD5_MAX};
            end else begin
               res = {2'b00, v5};
            end
         end
         LANE_FIELD6: begin
            sum = {1'b0, prod[13:6]} + {1'b0, ovl};
            v6  = sum[8:2];
            if (copy) begin
               res = {2'b00, ovl[7:2]};
            end else if (v6 > FIELD6_MAX) begin
               res = {1'b0, FIELD6_MAX};
            end else begin
               res = {1'b0, v6};
            end
         end
         default: begin
            res = copy ? ovl : (prod[15:8] + ovl);
         end
      endcase
      return res;
   endfunction

endpackage

// File: rtl/osd_alpha_blend.sv
// OSD alpha blender: blends one overlay pixel into one destination pixel word.
//
// Usage:
//   req_ channel carries the destination word, overlay byte and alpha byte.
//   rsp_ channel returns the blended word and a written flag. One result per
//   item, in order. csr_ port writes pixel_format (index 0) and copy_mode
//   (index 1); write it only while the pipeline is empty.
// Pipeline: three register stages (channel decode, 8x8 multiply per lane,
//   scale/saturate/assemble). An accepted item passes through stage 1, stage 2
//   and the output register before rsp_valid rises.
// Throughput: one item per clock while no stalled result is held; the three
//   pipeline registers advance together and are held as a group.
// Reset: clears all valid bits and sets pixel_format and copy_mode to 0.
// Stall: while rsp_stall holds a valid result the whole pipeline holds and
//   req_stall is raised in the same cycle; no item is lost or repeated.
//   Bubbles in the pipeline are not squeezed out.
module osd_alpha_blend (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dest_pixel,
   input  logic [7:0]  req_overlay_value,
   input  logic [7:0]  req_alpha,
   // item output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_blended_pixel,
   output logic        rsp_was_written,
   // configuration
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [2:0]  csr_data
);

   localparam int unsigned NL = osd_ab_pkg::NUM_LANES;

   logic [2:0]  fmt_ff;
   logic        copy_ff;
   logic        adv;

   // stage 1: decoded channels
   logic        s1_valid_ff;
   logic [31:0] s1_dest_ff;
   logic [7:0]  s1_ovl_ff;
   logic [7:0]  s1_alpha_ff;
   logic [2:0]  s1_fmt_ff;
   logic        s1_copy_ff;
   logic [7:0]  s1_chan_ff [NL];
   logic [7:0]  s1_chan_in [NL];

   // stage 2: products
   logic        s2_valid_ff;
   logic [31:0] s2_dest_ff;
   logic [7:0]  s2_ovl_ff;
   logic        s2_alpha_nz_ff;
   logic [2:0]  s2_fmt_ff;
   logic        s2_copy_ff;
   logic [15:0] s2_prod_ff [NL];

   // stage 3: output register
   logic        out_valid_ff;
   logic [31:0] out_pixel_ff;
   logic        out_written_ff;
   logic [7:0]  lane_res [NL];
   logic [31:0] out_pixel_in;
   logic        out_written_in;

   // Advance the whole pipeline unless a held result blocks the output
   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 3'd0;
         copy_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            osd_ab_pkg::CSR_PIXEL_FORMAT: fmt_ff  <= csr_data;
            osd_ab_pkg::CSR_COPY_MODE:    copy_ff <= csr_data[0];
            default:                      fmt_ff  <= fmt_ff;
         endcase
      end
   end

   // Pick the channel bits of the incoming word for the active format
   always_comb begin
      s1_chan_in[0] = req_dest_pixel[7:0];
      s1_chan_in[1] = req_dest_pixel[15:8];
      s1_chan_in[2] = req_dest_pixel[23:16];
      unique case (fmt_ff)
         osd_ab_pkg::FMT_RGB15: begin
            s1_chan_in[0] = {3'b000, req_dest_pixel[4:0]};
            s1_chan_in[1] = {3'b000, req_dest_pixel[9:5]};
            s1_chan_in[2] = {3'b000, req_dest_pixel[14:10]};
         end
         osd_ab_pkg::FMT_RGB16: begin
            s1_chan_in[0] = {3'b000, req_dest_pixel[4:0]};
            s1_chan_in[1] = {2'b00, req_dest_pixel[10:5]};
            s1_chan_in[2] = {3'b000, req_dest_pixel[15:11]};
         end
         default: begin
            s1_chan_in[0] = req_dest_pixel[7:0];
         end
      endcase
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: capture item, config and decoded channels
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dest_ff  <= req_dest_pixel;
         s1_ovl_ff   <= req_overlay_value;
         s1_alpha_ff <= req_alpha;
         s1_fmt_ff   <= fmt_ff;
         s1_copy_ff  <= copy_ff;
         for (int i = 0; i < NL; i++) begin
            s1_chan_ff[i] <= s1_chan_in[i];
         end
      end
   end

   // Stage 2: one 8x8 multiply per lane
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dest_ff     <= s1_dest_ff;
         s2_ovl_ff      <= s1_ovl_ff;
         s2_alpha_nz_ff <= (s1_alpha_ff != 8'd0);
         s2_fmt_ff      <= s1_fmt_ff;
         s2_copy_ff     <= s1_copy_ff;
         for (int i = 0; i < NL; i++) begin
            s2_prod_ff[i] <= s1_chan_ff[i] * s1_alpha_ff;
         end
      end
   end

   // Stage 3: scale, add overlay, saturate (field lanes) and reassemble the word
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         lane_res[i] = osd_ab_pkg::lane_blend(s2_prod_ff[i], s2_ovl_ff, s2_copy_ff,
                          osd_ab_pkg::lane_kind(s2_fmt_ff, 2'(i)));
      end
      out_pixel_in   = s2_dest_ff;
      out_written_in = 1'b0;
      if (s2_alpha_nz_ff) begin
         out_written_in = 1'b1;
         unique case (s2_fmt_ff)
            osd_ab_pkg::FMT_Y_PLANE,
            osd_ab_pkg::FMT_YUY2: begin
               out_pixel_in = {s2_dest_ff[31:8], lane_res[0]};
            end
            osd_ab_pkg::FMT_RGB24,
            osd_ab_pkg::FMT_RGB32: begin
               out_pixel_in = {s2_dest_ff[31:24], lane_res[2], lane_res[1], lane_res[0]};
            end
            osd_ab_pkg::FMT_RGB15: begin
               out_pixel_in = {s2_dest_ff[31:15], lane_res[2][4:0], lane_res[1][4:0],
                               lane_res[0][4:0]};
            end
            osd_ab_pkg::FMT_RGB16: begin
               out_pixel_in = {s2_dest_ff[31:16], lane_res[2][4:0], lane_res[1][5:0],
                               lane_res[0][4:0]};
            end
            default: begin
               out_written_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pixel_ff   <= out_pixel_in;
         out_written_ff <= out_written_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blended_pixel = out_pixel_ff;
   assign rsp_was_written   = out_written_ff;

endmodule

// File: rtl/osd_ab_checker.sv
// Port-level checker for the OSD alpha blender and its bind statement.
module osd_ab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_blended_pixel,
   input logic        rsp_was_written
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blended_pixel)
                                 && $stable(rsp_was_written))
      else $error("stalled result changed");

   // Stall input only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Deliver an accepted item when nothing stalls the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind osd_alpha_blend osd_ab_checker u_osd_ab_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_blended_pixel (rsp_blended_pixel),
   .rsp_was_written   (rsp_was_written)
);

// File: dv/osd_alpha_blend_chk.sv
`timescale 1ns / 100ps
// Checker for the OSD alpha blender: predicts the blended word for each item and compares.
module osd_alpha_blend_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_dest_pixel,
   input  logic [7:0]  req_overlay_value,
   input  logic [7:0]  req_alpha,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_blended_pixel,
   input  logic        rsp_was_written,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [2:0]  csr_data,
   output int          pending_count,
   output int          fail_count,
   output int          results_checked
);

   localparam int unsigned FIELD5_LIMIT = 'h1F;
   localparam int unsigned FIELD6_LIMIT = 'h3F;

   typedef struct packed {
      logic [31:0] pixel;
      logic        written;
   } blend_result_type;

   logic [2:0]       fmt_shadow;
   logic             copy_shadow;
   blend_result_type blend_expected[$];
   int               fails = 0;
   int               checked = 0;

   assign fail_count      = fails;
   assign results_checked = checked;

   // One 8-bit channel: scale by alpha, add overlay, wrap; copy mode returns the overlay
   function automatic logic [7:0] mix_byte(input logic [7:0] chan, input logic [7:0] ovl,
                                           input logic [7:0] alpha, input logic copy);
      logic [15:0] prod;
      prod = chan * alpha;
      if (copy) begin
         return ovl;
      end
      return prod[15:8] + ovl;
   endfunction

   // One 5- or 6-bit field: rescale, add overlay, drop to field width, saturate
   function automatic logic [5:0] mix_field(input logic [5:0] fld, input logic [7:0] ovl,
                                            input logic [7:0] alpha, input logic copy,
                                            input int unsigned bits);
      int unsigned fv, av, ov, limit, v;
      fv    = fld;
      av    = alpha;
      ov    = ovl;
      limit = (bits == 6) ? FIELD6_LIMIT : FIELD5_LIMIT;
      if (copy) begin
         return 6'(ov >> (8 - bits));
      end
      v = (((fv * av) >> bits) + ov) >> (8 - bits);
      if (v > limit) begin
         v = limit;
      end
      return 6'(v);
   endfunction

   // Whole pixel word under the current format and copy setting
   function automatic blend_result_type blend_pixel(input logic [31:0] dest,
                                                    input logic [7:0] ovl,
                                                    input logic [7:0] alpha,
                                                    input logic [2:0] fmt,
                                                    input logic copy);
      blend_result_type r;
      logic [5:0]       f0, f1, f2;
      r.pixel   = dest;
      r.written = 1'b0;
      if (alpha != 8'd0) begin
         r.written = 1'b1;
         case (fmt)
            osd_ab_pkg::FMT_Y_PLANE, osd_ab_pkg::FMT_YUY2: begin
               r.pixel[7:0] = mix_byte(dest[7:0], ovl, alpha, copy);
            end
            osd_ab_pkg::FMT_RGB24, osd_ab_pkg::FMT_RGB32: begin
               for (int k = 0; k < 3; k++) begin
                  r.pixel[8*k +: 8] = mix_byte(dest[8*k +: 8], ovl, alpha, copy);
               end
            end
            osd_ab_pkg::FMT_RGB15: begin
               f0 = mix_field({1'b0, dest[4:0]}, ovl, alpha, copy, 5);
               f1 = mix_field({1'b0, dest[9:5]}, ovl, alpha, copy, 5);
               f2 = mix_field({1'b0, dest[14:10]}, ovl, alpha, copy, 5);
               r.pixel[14:0] = {f2[4:0], f1[4:0], f0[4:0]};
            end
            osd_ab_pkg::FMT_RGB16: begin
               f0 = mix_field({1'b0, dest[4:0]}, ovl, alpha, copy, 5);
               f1 = mix_field(dest[10:5], ovl, alpha, copy, 6);
               f2 = mix_field({1'b0, dest[15:11]}, ovl, alpha, copy, 5);
               r.pixel[15:0] = {f2[4:0], f1, f0[4:0]};
            end
            default: begin
               // unknown format: word passes through untouched
               r.written = 1'b0;
            end
         endcase
      end
      return r;
   endfunction

   // Match results against the oldest prediction, then queue new items and track registers
   always @(posedge clock) begin : watch
      blend_result_type want;
      if (reset) begin
         fmt_shadow  <= osd_ab_pkg::FMT_Y_PLANE;
         copy_shadow <= 1'b0;
         blend_expected.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blend_expected.size() == 0) begin
               fails++;
               $display("%0t: result with no item pending: pixel=%h written=%b",
                        $time, rsp_blended_pixel, rsp_was_written);
            end else begin
               want = blend_expected.pop_front();
               checked++;
               if (rsp_blended_pixel !== want.pixel) begin
                  fails++;
                  $display("%0t: blended_pixel expected %h actual %h",
                           $time, want.pixel, rsp_blended_pixel);
               end
               if (rsp_was_written !== want.written) begin
                  fails++;
                  $display("%0t: was_written expected %b actual %b",
                           $time, want.written, rsp_was_written);
               end
            end
         end
         if (req_valid && !req_stall) begin
            blend_expected.push_back(blend_pixel(req_dest_pixel, req_overlay_value, req_alpha,
                                                 fmt_shadow, copy_shadow));
         end
         if (csr_write) begin
            case (csr_index)
               osd_ab_pkg::CSR_PIXEL_FORMAT: fmt_shadow  <= csr_data;
               osd_ab_pkg::CSR_COPY_MODE:    copy_shadow <= csr_data[0];
               default:                      ;
            endcase
         end
         pending_count <= blend_expected.size();
      end
   end

endmodule

// File: dv/osd_alpha_blend_tb.sv
`timescale 1ns / 100ps
// Testbench top for the OSD alpha blender: clock, reset, stimulus, stalls and verdict.
module osd_alpha_blend_tb;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned RANDOM_PER_MODE = 50;
   localparam logic [2:0]  FMT_SPARE_LO    = 3'd6;
   localparam logic [2:0]  FMT_SPARE_HI    = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_dest_pixel = '0;
   logic [7:0]  req_overlay_value = '0;
   logic [7:0]  req_alpha = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_blended_pixel;
   logic        rsp_was_written;
   logic        csr_write = 1'b0;
   logic        csr_index = osd_ab_pkg::CSR_PIXEL_FORMAT;
   logic [2:0]  csr_data = '0;

   int          pending_count;
   int          fail_count;
   int          results_checked;
   int unsigned items_sent = 0;
   int unsigned modes_set = 0;
   int unsigned cycle_count = 0;
   bit          idle_off = 1'b0;

   always #10 clock = ~clock;

   osd_alpha_blend uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dest_pixel    (req_dest_pixel),
      .req_overlay_value (req_overlay_value),
      .req_alpha         (req_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel),
      .rsp_was_written   (rsp_was_written),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   osd_alpha_blend_chk chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dest_pixel    (req_dest_pixel),
      .req_overlay_value (req_overlay_value),
      .req_alpha         (req_alpha),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel),
      .rsp_was_written   (rsp_was_written),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .pending_count     (pending_count),
      .fail_count        (fail_count),
      .results_checked   (results_checked)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stall the result side: free runs alternating with stalls, mostly short; no stalls while idle_off is set
   initial begin : stall_gen
      int unsigned run_len, hold_len, pick;
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         run_len = (pick < 60) ? $urandom_range(1, 4) :
                   (pick < 90) ? $urandom_range(5, 20) : $urandom_range(50, 150);
         repeat (run_len) @(posedge clock);
         if (!idle_off) begin
            pick = $urandom_range(0, 99);
            hold_len = (pick < 70) ? $urandom_range(1, 3) :
                       (pick < 95) ? $urandom_range(4, 10) : $urandom_range(20, 40);
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Gap before the next item: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (idle_off || pick < 55) begin
         return 0;
      end
      return (pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
   endfunction

   // Present one item and hold it until accepted
   task automatic send_item(input logic [31:0] dest, input logic [7:0] ovl,
                            input logic [7:0] alpha);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_dest_pixel    <= dest;
      req_overlay_value <= ovl;
      req_alpha         <= alpha;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Stop sending and wait until every queued item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Write both registers once the pipeline is empty
   task automatic set_mode(input logic [2:0] fmt, input logic copy);
      logic [1:0] junk;
      junk = 2'($urandom_range(0, 3));
      drain_results();
      csr_write <= 1'b1;
      csr_index <= osd_ab_pkg::CSR_PIXEL_FORMAT;
      csr_data  <= fmt;
      @(posedge clock);
      csr_index <= osd_ab_pkg::CSR_COPY_MODE;
      csr_data  <= {junk, copy};
      @(posedge clock);
      csr_write <= 1'b0;
      modes_set++;
   endtask

   // Random item with extra weight on field extremes
   task automatic random_item();
      logic [31:0] dest;
      logic [7:0]  ovl, alpha;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      dest = (pick < 10) ? 32'h0000_0000 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 99);
      ovl  = (pick < 15) ? 8'h00 : (pick < 30) ? 8'hFF : 8'($urandom);
      pick = $urandom_range(0, 99);
      alpha = (pick < 10) ? 8'h00 : (pick < 25) ? 8'hFF : (pick < 30) ? 8'h01 : 8'($urandom);
      send_item(dest, ovl, alpha);
   endtask

   initial begin : main
      int mode_idx;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Y plane blend after reset: zero alpha, byte wrap, minimum values
      send_item(32'hFFFF_FFFF, 8'hFF, 8'h00);
      send_item(32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_item(32'h0000_0000, 8'h00, 8'h01);
      send_item(32'h1234_5680, 8'h7F, 8'h80);

      // 16 bpp: saturation of all three fields, zero overlay, zero alpha
      set_mode(osd_ab_pkg::FMT_RGB16, 1'b0);
      send_item(32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_item(32'h0000_FFFF, 8'h00, 8'hFF);
      send_item(32'hA5A5_07E0, 8'h10, 8'h00);

      // 15 bpp: saturation and a mid-range blend
      set_mode(osd_ab_pkg::FMT_RGB15, 1'b0);
      send_item(32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_item(32'h0000_7FFF, 8'h08, 8'h40);

      // copy mode across formats
      set_mode(osd_ab_pkg::FMT_RGB24, 1'b1);
      send_item(32'h89AB_CDEF, 8'h5A, 8'h01);
      send_item(32'h89AB_CDEF, 8'h5A, 8'h00);
      set_mode(osd_ab_pkg::FMT_RGB16, 1'b1);
      send_item(32'hFFFF_0000, 8'hFF, 8'h01);
      set_mode(osd_ab_pkg::FMT_RGB15, 1'b1);
      send_item(32'h8000_0000, 8'hF8, 8'hFF);
      set_mode(osd_ab_pkg::FMT_YUY2, 1'b1);
      send_item(32'hFFFF_FF00, 8'hFF, 8'h80);

      // unknown format codes pass the word through
      set_mode(FMT_SPARE_LO, 1'b0);
      send_item(32'hDEAD_BEEF, 8'hFF, 8'hFF);
      set_mode(FMT_SPARE_HI, 1'b1);
      send_item(32'h0F0F_F0F0, 8'h80, 8'h01);

      // 32 bpp: top byte must pass through
      set_mode(osd_ab_pkg::FMT_RGB32, 1'b0);
      send_item(32'hFFFF_FFFF, 8'h01, 8'hFF);

      // sweep every format and copy setting with random items
      for (mode_idx = 0; mode_idx < 16; mode_idx++) begin
         set_mode(3'(mode_idx / 2), 1'(mode_idx % 2));
         idle_off = (mode_idx % 5 == 3);
         repeat (RANDOM_PER_MODE / 2) random_item();
         // hold off mid-phase until the pipeline empties
         if (mode_idx % 3 == 0) begin
            drain_results();
         end
         repeat (RANDOM_PER_MODE - RANDOM_PER_MODE / 2) random_item();
      end
      idle_off = 1'b0;

      // two more phases at randomly chosen settings
      repeat (2) begin
         set_mode(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         repeat (25) random_item();
      end

      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d items over %0d register settings (all formats, copy on and off).",
               items_sent, modes_set);
      $display("Checked %0d results, %0d still outstanding, %0d mismatches.",
               results_checked, pending_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
